[hdl/key_debounce_and_beep_sequencer_top_macros.svh]
// Assertion macros shared by the block's modules.
`ifndef KEY_DEBOUNCE_AND_BEEP_SEQUENCER_TOP_MACROS_SVH
`define KEY_DEBOUNCE_AND_BEEP_SEQUENCER_TOP_MACROS_SVH

// The condition must hold at every clock edge outside reset.
`define KDB_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// The consequence must hold in the same cycle as the trigger.
`define KDB_ASSERT_NOW(lbl, trig, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cons)) \
    else $error(msg);

// The consequence must hold in the cycle after the trigger.
`define KDB_ASSERT_NEXT(lbl, trig, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
    else $error(msg);

`endif

[hdl/kdb_pkg.sv]
package kdb_pkg;

  localparam int KDB_NUM_BUTTONS = 4;
  localparam int KDB_STEP_W      = 8;
  localparam int KDB_CFG_IDX_W   = 2;

  localparam logic [1:0] CMD_TICK      = 2'd0;
  localparam logic [1:0] CMD_LOAD_PAT  = 2'd1;
  localparam logic [1:0] CMD_LOAD_RING = 2'd2;

  localparam logic [KDB_CFG_IDX_W-1:0] CFG_RING_STEP_TICKS    = 2'd0;
  localparam logic [KDB_CFG_IDX_W-1:0] CFG_PATTERN_STEP_TICKS = 2'd1;

  localparam logic [KDB_STEP_W-1:0] RING_STEP_TICKS_RESET    = 8'd2;
  localparam logic [KDB_STEP_W-1:0] PATTERN_STEP_TICKS_RESET = 8'd20;

  typedef struct packed {
    logic [1:0]                 cmd;
    logic [KDB_NUM_BUTTONS-1:0] button_pins;
    logic [KDB_STEP_W-1:0]      load_value;
  } in_item_t;

  typedef struct packed {
    logic [KDB_NUM_BUTTONS-1:0] press_events;
    logic                       buzzer_on;
  } out_item_t;

  typedef struct packed {
    logic tick;
    logic load_pat;
    logic load_ring;
  } kdb_ctrl_t;

  typedef struct packed {
    logic [KDB_STEP_W-1:0] ring_step_ticks;
    logic [KDB_STEP_W-1:0] pattern_step_ticks;
  } kdb_cfg_t;

endpackage

[hdl/kdb_debounce.sv]
module kdb_debounce
  import kdb_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  kdb_ctrl_t                  ctrl,
  input  logic [KDB_NUM_BUTTONS-1:0] pins,
  output logic [KDB_NUM_BUTTONS-1:0] events
);

  logic [KDB_NUM_BUTTONS-1:0] seen_r, seen_nxt;
  logic [KDB_NUM_BUTTONS-1:0] rep_r, rep_nxt;

  always_comb begin
    seen_nxt = seen_r;
    rep_nxt  = rep_r;
    events   = '0;
    if (ctrl.tick) begin
      for (int i = 0; i < KDB_NUM_BUTTONS; i++) begin
        if (!pins[i]) begin
          if (seen_r[i] ^ rep_r[i]) begin
            rep_nxt[i] = 1'b1;
            events[i]  = 1'b1;
          end else begin
            seen_nxt[i] = 1'b1;
          end
        end else begin
          seen_nxt[i] = 1'b0;
          rep_nxt[i]  = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= '0;
      rep_r  <= '0;
    end else begin
      seen_r <= seen_nxt;
      rep_r  <= rep_nxt;
    end
  end

`include "key_debounce_and_beep_sequencer_top_macros.svh"

  `KDB_ASSERT_ALWAYS(a_rep_implies_seen, (rep_r & ~seen_r) == '0, "reported press without seen low")
  `KDB_ASSERT_NEXT(a_event_marks_reported, events != '0, (rep_r & $past(events)) == $past(events), "press event not recorded")

endmodule

[hdl/kdb_buzzer.sv]
module kdb_buzzer
  import kdb_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  kdb_ctrl_t             ctrl,
  input  kdb_cfg_t              cfg,
  input  logic [KDB_STEP_W-1:0] load_value,
  output logic                  buzzer_nxt
);

  logic [KDB_STEP_W-1:0] wait_r, wait_nxt;
  logic [KDB_STEP_W-1:0] ring_r, ring_nxt;
  logic [KDB_STEP_W-1:0] pat_r, pat_nxt;
  logic                  buzz_r;

  always_comb begin
    wait_nxt   = wait_r;
    ring_nxt   = ring_r;
    pat_nxt    = pat_r;
    buzzer_nxt = buzz_r;
    if (ctrl.load_pat) begin
      pat_nxt    = load_value;
      buzzer_nxt = 1'b1;
      wait_nxt   = cfg.pattern_step_ticks;
    end else if (ctrl.load_ring) begin
      ring_nxt   = load_value;
      buzzer_nxt = 1'b1;
      wait_nxt   = cfg.ring_step_ticks;
    end else if (ctrl.tick) begin
      if (wait_r != '0) begin
        wait_nxt = wait_r - 1'b1;
      end else if (ring_r != '0) begin
        wait_nxt   = cfg.ring_step_ticks;
        buzzer_nxt = ring_r[0];
        ring_nxt   = ring_r - 1'b1;
      end else if (pat_r != '0) begin
        wait_nxt   = cfg.pattern_step_ticks;
        buzzer_nxt = pat_r[0];
        pat_nxt    = pat_r >> 1;
      end else begin
        buzzer_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wait_r <= '0;
      ring_r <= '0;
      pat_r  <= '0;
      buzz_r <= 1'b0;
    end else begin
      wait_r <= wait_nxt;
      ring_r <= ring_nxt;
      pat_r  <= pat_nxt;
      buzz_r <= buzzer_nxt;
    end
  end

`include "key_debounce_and_beep_sequencer_top_macros.svh"

  `KDB_ASSERT_NEXT(a_wait_counts_down, ctrl.tick && wait_r != '0, wait_r == $past(wait_r) - 1'b1 && buzz_r == $past(buzz_r), "step wait did not count down")

endmodule

[hdl/key_debounce_and_beep_sequencer_top.sv]
// Debounces four active-low buttons and runs a buzzer sequencer, both advanced
// by tick requests; load requests set up a ring burst or a beep pattern. One
// request is taken every clock cycle unless the result side stalls, and each
// gives one result: the request passes an input register, the state update and
// result are formed from it, and the result waits in an output register. A
// stall on the result side backs up through both registers. Configuration
// writes are always taken and must only be made while the block is idle.
module key_debounce_and_beep_sequencer_top
  import kdb_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  in_item_t                 in_data,
  output logic                     out_valid,
  input  logic                     out_stall,
  output out_item_t                out_data,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [KDB_CFG_IDX_W-1:0] cfg_index,
  input  logic [KDB_STEP_W-1:0]    cfg_data
);

  logic      s1_valid_r;
  in_item_t  s1_item_r;
  logic      out_valid_r;
  out_item_t out_item_r;
  logic      advance;
  kdb_ctrl_t ctrl;
  kdb_cfg_t  cfg_r;
  logic [KDB_NUM_BUTTONS-1:0] events;
  logic      buzzer_nxt;

  assign advance   = !out_valid_r || !out_stall;
  assign in_stall  = s1_valid_r && !advance;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

  always_comb begin
    ctrl = '0;
    if (s1_valid_r && advance) begin
      case (s1_item_r.cmd)
        CMD_TICK:      ctrl.tick      = 1'b1;
        CMD_LOAD_PAT:  ctrl.load_pat  = 1'b1;
        CMD_LOAD_RING: ctrl.load_ring = 1'b1;
        default:       ctrl = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ring_step_ticks    <= RING_STEP_TICKS_RESET;
      cfg_r.pattern_step_ticks <= PATTERN_STEP_TICKS_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_RING_STEP_TICKS:    cfg_r.ring_step_ticks    <= cfg_data;
        CFG_PATTERN_STEP_TICKS: cfg_r.pattern_step_ticks <= cfg_data;
        default:                cfg_r <= cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (!in_stall) begin
        s1_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_item_r <= in_data;
    end
    if (s1_valid_r && advance) begin
      out_item_r.press_events <= events;
      out_item_r.buzzer_on    <= buzzer_nxt;
    end
  end

  kdb_debounce u_debounce (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (ctrl),
    .pins   (s1_item_r.button_pins),
    .events (events)
  );

  kdb_buzzer u_buzzer (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (ctrl),
    .cfg        (cfg_r),
    .load_value (s1_item_r.load_value),
    .buzzer_nxt (buzzer_nxt)
  );

`include "key_debounce_and_beep_sequencer_top_macros.svh"

  `KDB_ASSERT_NEXT(a_accept_fills_stage, in_valid && !in_stall, s1_valid_r, "accepted request lost")
  `KDB_ASSERT_NOW(a_load_no_events, s1_valid_r && s1_item_r.cmd != CMD_TICK, events == '0, "events on a non-tick request")

endmodule
